[src/assert_macros.svh]
// Assertion helpers for the RTL, included by the drive unit.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that, when seen, requires another in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[src/hbpwm_pkg.sv]
// ----------------------------------------------------------------------------
// hbpwm_pkg
// Types, register indexes and helper arithmetic for the H-bridge PWM drive.
// ----------------------------------------------------------------------------
package hbpwm_pkg;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;
	localparam int DIV_BITS       = 11;
	localparam int CMP_BITS       = 14;
	localparam int DUTY_BITS      = 8;

	localparam logic [DIV_BITS-1:0] DIV_MIN   = 11'd1;
	localparam logic [DIV_BITS-1:0] DIV_MAX   = 11'd1024;
	localparam logic [DIV_BITS-1:0] DIV_RESET = 11'd64;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FREQ_DIVIDER   = 3'd0,
		REG_MIN_SEEK       = 3'd1,
		REG_MAX_SEEK       = 3'd2,
		REG_REV_SEEK       = 3'd3,
		REG_DRIVE_ENABLE   = 3'd4,
		REG_SWAP_DIRECTION = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [DIV_BITS-1:0]      freq_divider;
		logic [CFG_DATA_BITS-1:0] min_seek;
		logic [CFG_DATA_BITS-1:0] max_seek;
		logic                     reverse_seek;
		logic                     drive_enable;
		logic                     swap_direction;
	} cfg_t;

	// Exact floor(x / 255) for x below 65535, using x/255 = (x + x/256 + 1) / 256.
	function automatic logic [8:0] div255(input logic [15:0] x);
		logic [16:0] sum;
		sum = 17'(x) + 17'(x[15:8]) + 17'd1;
		return sum[16:8];
	endfunction

endpackage

[src/hbpwm_cfg.sv]
// ----------------------------------------------------------------------------
// hbpwm_cfg
// Configuration register file. Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module hbpwm_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [hbpwm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [hbpwm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output hbpwm_pkg::cfg_t                      cfg_regs
);
	import hbpwm_pkg::*;

	cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign cfg_regs  = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.freq_divider   <= DIV_RESET;
			regs_q.min_seek       <= '0;
			regs_q.max_seek       <= 16'd1023;
			regs_q.reverse_seek   <= 1'b0;
			regs_q.drive_enable   <= 1'b0;
			regs_q.swap_direction <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_FREQ_DIVIDER:   regs_q.freq_divider   <= cfg_data[DIV_BITS-1:0];
				REG_MIN_SEEK:       regs_q.min_seek       <= cfg_data;
				REG_MAX_SEEK:       regs_q.max_seek       <= cfg_data;
				REG_REV_SEEK:       regs_q.reverse_seek   <= cfg_data[0];
				REG_DRIVE_ENABLE:   regs_q.drive_enable   <= cfg_data[0];
				REG_SWAP_DIRECTION: regs_q.swap_direction <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

[src/hbpwm_scale.sv]
// ----------------------------------------------------------------------------
// hbpwm_scale
// Period top and duty-to-compare scaling, duty * top / 255, split as
// duty * (top / 255) + duty * (top mod 255) / 255 so no wide divide is needed.
// ----------------------------------------------------------------------------
module hbpwm_scale (
	input  logic [hbpwm_pkg::DUTY_BITS-1:0] duty,
	input  logic [hbpwm_pkg::DIV_BITS-1:0]  divider,
	output logic [hbpwm_pkg::CMP_BITS-1:0]  period_top,
	output logic [hbpwm_pkg::CMP_BITS-1:0]  compare
);
	import hbpwm_pkg::*;

	logic [14:0] top_wide;
	logic [8:0]  top_quo;
	logic [15:0] top_rem_wide;
	logic [7:0]  top_rem;
	logic [15:0] prod_quo;
	logic [15:0] prod_rem;
	logic [8:0]  rem_quo;
	logic [15:0] cmp_wide;

	assign top_wide     = (15'(divider) << 4) - 15'd1;
	assign period_top   = top_wide[CMP_BITS-1:0];
	assign top_quo      = div255(16'(top_wide));
	assign top_rem_wide = 16'(top_wide) - ((16'(top_quo) << 8) - 16'(top_quo));
	assign top_rem      = top_rem_wide[7:0];
	assign prod_quo     = 16'(duty) * 16'(top_quo);
	assign prod_rem     = 16'(duty) * 16'(top_rem);
	assign rem_quo      = div255(prod_rem);
	assign cmp_wide     = prod_quo + 16'(rem_quo);
	assign compare      = cmp_wide[CMP_BITS-1:0];

endmodule

[src/hbridge_pwm_drive_with_limits_unit.sv]
// ----------------------------------------------------------------------------
// hbridge_pwm_drive_with_limits_unit
// H-bridge PWM drive update with seek limits, side selection and scaling.
// ----------------------------------------------------------------------------
// The unit accepts one drive update per clock cycle unless a stalled result holds
// the input; an accepted update is first loaded into the input register and then,
// once the result side is not stalled, into the result register. Every item reads
// and writes the held side duties and active divider. A stalled result holds the
// input register, so at most two updates are in flight. Configuration writes are
// taken in any cycle and should only be issued while no update is in flight.
module hbridge_pwm_drive_with_limits_unit #(
	parameter int POSITION_BITS = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [POSITION_BITS-1:0] position,
	input  logic signed [8:0]        drive,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [13:0]              compare_a,
	output logic [13:0]              compare_b,
	output logic                     side_a_on,
	output logic                     side_b_on,
	output logic [13:0]              period_top,
	output logic                     break_before_make,
	output logic                     counter_restart,
	output logic [7:0]               duty_a,
	output logic [7:0]               duty_b,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [2:0]               cfg_index,
	input  logic [15:0]              cfg_data
);
	import hbpwm_pkg::*;

	localparam logic [POSITION_BITS-1:0] POS_FULL = '1;

	cfg_t cfg_regs;

	logic                     s1_valid_q;
	logic [POSITION_BITS-1:0] position_s1;
	logic signed [8:0]        drive_s1;

	logic [DUTY_BITS-1:0] duty_a_q;
	logic [DUTY_BITS-1:0] duty_b_q;
	logic [DIV_BITS-1:0]  active_div_q;

	logic                 out_valid_q;
	logic [CMP_BITS-1:0]  compare_a_q;
	logic [CMP_BITS-1:0]  compare_b_q;
	logic [CMP_BITS-1:0]  period_top_q;
	logic                 bbm_q;
	logic                 restart_q;

	logic                     out_busy;
	logic                     advance;
	logic [DIV_BITS-1:0]      div_c;
	logic [POSITION_BITS-1:0] min_c;
	logic [POSITION_BITS-1:0] max_c;
	logic [POSITION_BITS-1:0] lo_lim;
	logic [POSITION_BITS-1:0] hi_lim;
	logic signed [8:0]        drive_sat;
	logic [8:0]               drive_neg;
	logic [DUTY_BITS-1:0]     mag;
	logic                     is_neg;
	logic                     stop;
	logic                     to_a;
	logic                     restart;
	logic [DUTY_BITS-1:0]     base_a;
	logic [DUTY_BITS-1:0]     base_b;
	logic [DUTY_BITS-1:0]     duty_a_nx;
	logic [DUTY_BITS-1:0]     duty_b_nx;
	logic                     bbm;
	logic [CMP_BITS-1:0]      scaled;
	logic [CMP_BITS-1:0]      top_nx;

	hbpwm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_regs  (cfg_regs)
	);

	hbpwm_scale u_scale (
		.duty       (mag),
		.divider    (div_c),
		.period_top (top_nx),
		.compare    (scaled)
	);

	assign out_busy = out_valid_q && out_stall;
	assign advance  = s1_valid_q && !out_busy;
	assign in_stall = s1_valid_q && out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			position_s1 <= position;
			drive_s1    <= drive;
		end
	end

	always_comb begin
		if (cfg_regs.freq_divider < DIV_MIN) begin
			div_c = DIV_MIN;
		end else if (cfg_regs.freq_divider > DIV_MAX) begin
			div_c = DIV_MAX;
		end else begin
			div_c = cfg_regs.freq_divider;
		end
	end

	assign min_c = (cfg_regs.min_seek > 16'(POS_FULL)) ? POS_FULL
		: cfg_regs.min_seek[POSITION_BITS-1:0];
	assign max_c = (cfg_regs.max_seek > 16'(POS_FULL)) ? POS_FULL
		: cfg_regs.max_seek[POSITION_BITS-1:0];
	assign lo_lim = cfg_regs.reverse_seek ? (POS_FULL - max_c) : min_c;
	assign hi_lim = cfg_regs.reverse_seek ? (POS_FULL - min_c) : max_c;

	assign drive_sat = (drive_s1 == -9'sd256) ? -9'sd255 : drive_s1;
	assign is_neg    = drive_sat[8];
	assign drive_neg = 9'(-drive_sat);
	assign mag       = is_neg ? drive_neg[7:0] : drive_sat[7:0];
	assign stop      = (drive_sat == 9'sd0) || !cfg_regs.drive_enable
		|| ((position_s1 < lo_lim) && is_neg)
		|| ((position_s1 > hi_lim) && !is_neg);
	assign to_a      = !is_neg ^ cfg_regs.swap_direction;

	assign restart = div_c != active_div_q;
	assign base_a  = restart ? '0 : duty_a_q;
	assign base_b  = restart ? '0 : duty_b_q;

	always_comb begin
		bbm       = restart;
		duty_a_nx = base_a;
		duty_b_nx = base_b;
		if (stop) begin
			if (base_a != '0 || base_b != '0) begin
				bbm       = 1'b1;
				duty_a_nx = '0;
				duty_b_nx = '0;
			end
		end else if (to_a) begin
			if (base_a == '0 || base_b != '0) begin
				bbm       = 1'b1;
				duty_b_nx = '0;
			end
			duty_a_nx = mag;
		end else begin
			if (base_b == '0 || base_a != '0) begin
				bbm       = 1'b1;
				duty_a_nx = '0;
			end
			duty_b_nx = mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_a_q     <= '0;
			duty_b_q     <= '0;
			active_div_q <= DIV_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= advance || out_busy;
			if (advance) begin
				duty_a_q     <= duty_a_nx;
				duty_b_q     <= duty_b_nx;
				active_div_q <= div_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			compare_a_q  <= (!stop && to_a) ? scaled : '0;
			compare_b_q  <= (!stop && !to_a) ? scaled : '0;
			period_top_q <= top_nx;
			bbm_q        <= bbm;
			restart_q    <= restart;
		end
	end

	assign out_valid         = out_valid_q;
	assign compare_a         = compare_a_q;
	assign compare_b         = compare_b_q;
	assign side_a_on         = duty_a_q != '0;
	assign side_b_on         = duty_b_q != '0;
	assign period_top        = period_top_q;
	assign break_before_make = bbm_q;
	assign counter_restart   = restart_q;
	assign duty_a            = duty_a_q;
	assign duty_b            = duty_b_q;

	`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_sides_exclusive, !(duty_a_q != '0 && duty_b_q != '0), "both sides held on")
	`ASSERT_IMPLY(a_restart_bbm, out_valid_q && restart_q, bbm_q, "restart without break")
	`ASSERT_IMPLY(a_cmp_a_side, out_valid_q && compare_a_q != '0, duty_a_q != '0, "compare A while A off")
	`ASSERT_IMPLY(a_cmp_b_side, out_valid_q && compare_b_q != '0, duty_b_q != '0, "compare B while B off")
	`ASSERT_IMPLY(a_top_divider, out_valid_q, period_top_q == 14'((15'(active_div_q) << 4) - 15'd1), "period top mismatch")

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the H-bridge PWM drive update with seek limits.
// Drive updates are fed from a queue with random sender gaps and receiver
// stalls. Every accepted update is run through a local predictor of the held
// side duties and active divider, and each result is compared field by field.
// Register settings change only between phases, once the unit has drained.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import hbpwm_pkg::*;

	localparam int POS_FULL       = 1023;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PHASES  = 12;
	localparam int CMDS_PER_PHASE = 53;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic [9:0]        pos;
		logic signed [8:0] drv;
	} drive_cmd_t;

	typedef struct packed {
		logic [CMP_BITS-1:0]  compare_a;
		logic [CMP_BITS-1:0]  compare_b;
		logic                 side_a_on;
		logic                 side_b_on;
		logic [CMP_BITS-1:0]  period_top;
		logic                 break_before_make;
		logic                 counter_restart;
		logic [DUTY_BITS-1:0] duty_a;
		logic [DUTY_BITS-1:0] duty_b;
	} bridge_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [9:0]                position = '0;
	logic signed [8:0]         drive = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [13:0]               compare_a;
	logic [13:0]               compare_b;
	logic                      side_a_on;
	logic                      side_b_on;
	logic [13:0]               period_top;
	logic                      break_before_make;
	logic                      counter_restart;
	logic [7:0]                duty_a;
	logic [7:0]                duty_b;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	// Register copy and held state of the predictor.
	logic [DIV_BITS-1:0]      cfg_div;
	logic [CFG_DATA_BITS-1:0] cfg_min;
	logic [CFG_DATA_BITS-1:0] cfg_max;
	logic                     cfg_rev;
	logic                     cfg_en;
	logic                     cfg_swap;
	logic [DUTY_BITS-1:0]     a_duty;
	logic [DUTY_BITS-1:0]     b_duty;
	logic [DIV_BITS-1:0]      act_div;

	drive_cmd_t     pending_cmds[$];
	bridge_result_t expected_q[$];
	bridge_result_t head;

	logic idle_on = 1'b1;
	int   send_gap = 0;
	int   stall_left = 0;
	int   quiet_cycles = 0;
	int   cmds_queued = 0;
	int   cmds_accepted = 0;
	int   results_seen = 0;
	int   reg_writes = 0;
	int   settings_used = 0;
	int   bbm_seen = 0;
	int   restart_seen = 0;
	int   mismatches = 0;

	hbridge_pwm_drive_with_limits_unit i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.position          (position),
		.drive             (drive),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.compare_a         (compare_a),
		.compare_b         (compare_b),
		.side_a_on         (side_a_on),
		.side_b_on         (side_b_on),
		.period_top        (period_top),
		.break_before_make (break_before_make),
		.counter_restart   (counter_restart),
		.duty_a            (duty_a),
		.duty_b            (duty_b),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int clamp_limit(input logic [CFG_DATA_BITS-1:0] v);
		return (v > POS_FULL) ? POS_FULL : int'(v);
	endfunction

	function automatic bridge_result_t update_bridge(input logic [9:0] pos,
			input logic signed [8:0] drv);
		bridge_result_t r;
		int d;
		int dv;
		int lo;
		int hi;
		int top;
		int duty;
		bit to_a;
		r = '0;
		d = drv;
		if (d < -255)
			d = -255;
		dv = int'(cfg_div);
		if (dv < 1)
			dv = 1;
		if (dv > 1024)
			dv = 1024;
		if (dv != int'(act_div)) begin
			r.break_before_make = 1'b1;
			r.counter_restart = 1'b1;
			a_duty = '0;
			b_duty = '0;
			act_div = DIV_BITS'(dv);
		end
		if (cfg_rev) begin
			lo = POS_FULL - clamp_limit(cfg_max);
			hi = POS_FULL - clamp_limit(cfg_min);
		end else begin
			lo = clamp_limit(cfg_min);
			hi = clamp_limit(cfg_max);
		end
		if (int'(pos) < lo && d < 0)
			d = 0;
		if (int'(pos) > hi && d > 0)
			d = 0;
		if (!cfg_en)
			d = 0;
		top = int'(act_div) * 16 - 1;
		if (d == 0) begin
			if (a_duty != 0 || b_duty != 0) begin
				r.break_before_make = 1'b1;
				a_duty = '0;
				b_duty = '0;
			end
		end else begin
			duty = (d < 0) ? -d : d;
			to_a = (d > 0) != cfg_swap;
			if (to_a) begin
				if (a_duty == 0 || b_duty != 0) begin
					r.break_before_make = 1'b1;
					b_duty = '0;
				end
				a_duty = DUTY_BITS'(duty);
				r.compare_a = CMP_BITS'(duty * top / 255);
			end else begin
				if (b_duty == 0 || a_duty != 0) begin
					r.break_before_make = 1'b1;
					a_duty = '0;
				end
				b_duty = DUTY_BITS'(duty);
				r.compare_b = CMP_BITS'(duty * top / 255);
			end
		end
		r.side_a_on = (a_duty != 0);
		r.side_b_on = (b_duty != 0);
		r.period_top = CMP_BITS'(top);
		r.duty_a = a_duty;
		r.duty_b = b_duty;
		return r;
	endfunction

	// Register writes and accepted updates both advance the predictor here.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_div = DIV_RESET;
			cfg_min = '0;
			cfg_max = CFG_DATA_BITS'(POS_FULL);
			cfg_rev = 1'b0;
			cfg_en = 1'b0;
			cfg_swap = 1'b0;
			a_duty = '0;
			b_duty = '0;
			act_div = DIV_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				reg_writes++;
				case (cfg_index)
					REG_FREQ_DIVIDER:   cfg_div = cfg_data[DIV_BITS-1:0];
					REG_MIN_SEEK:       cfg_min = cfg_data;
					REG_MAX_SEEK:       cfg_max = cfg_data;
					REG_REV_SEEK:       cfg_rev = cfg_data[0];
					REG_DRIVE_ENABLE:   cfg_en = cfg_data[0];
					REG_SWAP_DIRECTION: cfg_swap = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				expected_q.push_back(update_bridge(position, drive));
				cmds_accepted++;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			position <= '0;
			drive <= '0;
			send_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				in_valid <= 1'b0;
				send_gap <= $urandom_range(0, 15);
			end else if (pending_cmds.size() != 0) begin
				in_valid <= 1'b1;
				position <= pending_cmds[0].pos;
				drive <= pending_cmds[0].drv;
				pending_cmds.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 15);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				$display("%0t: result transfer with no update outstanding", $time);
			end else begin
				head = expected_q.pop_front();
				results_seen++;
				bbm_seen += head.break_before_make;
				restart_seen += head.counter_restart;
				check_field("compare_a", head.compare_a, compare_a);
				check_field("compare_b", head.compare_b, compare_b);
				check_field("side_a_on", head.side_a_on, side_a_on);
				check_field("side_b_on", head.side_b_on, side_b_on);
				check_field("period_top", head.period_top, period_top);
				check_field("break_before_make", head.break_before_make,
					break_before_make);
				check_field("counter_restart", head.counter_restart, counter_restart);
				check_field("duty_a", head.duty_a, duty_a);
				check_field("duty_b", head.duty_b, duty_b);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_settings(input logic [15:0] div, input logic [15:0] mn,
			input logic [15:0] mx, input logic rev, input logic en, input logic swap);
		write_reg(REG_FREQ_DIVIDER, div);
		write_reg(REG_MIN_SEEK, mn);
		write_reg(REG_MAX_SEEK, mx);
		write_reg(REG_REV_SEEK, {15'($urandom), rev});
		write_reg(REG_DRIVE_ENABLE, {15'($urandom), en});
		write_reg(REG_SWAP_DIRECTION, {15'($urandom), swap});
		settings_used++;
	endtask

	task automatic queue_cmd(input int pos, input int drv);
		drive_cmd_t c;
		c.pos = 10'(pos);
		c.drv = 9'(drv);
		pending_cmds.push_back(c);
		cmds_queued++;
	endtask

	// Runs of one direction with varying magnitude, stops, and positions
	// around the active limits, plus raw noise on both fields.
	task automatic queue_random(input int n, input int lo, input int hi);
		int k;
		int heading;
		int mag;
		int p;
		int d;
		heading = ($urandom_range(0, 1) == 0) ? 1 : -1;
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 5) == 0)
				heading = -heading;
			mag = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 255));
			d = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 511)) : heading * mag;
			case ($urandom_range(0, 3))
				1: p = lo + int'($urandom_range(0, 8)) - 4;
				2: p = hi + int'($urandom_range(0, 8)) - 4;
				default: p = int'($urandom_range(0, POS_FULL));
			endcase
			if (p < 0)
				p = 0;
			if (p > POS_FULL)
				p = POS_FULL;
			queue_cmd(p, d);
		end
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (cmds_accepted != cmds_queued || expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int phase;
		logic [15:0] div;
		logic [15:0] mn;
		logic [15:0] mx;
		logic rev;
		logic en;
		logic swap;
		int lo;
		int hi;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		apply_settings(16'd64, 16'd100, 16'd900, 1'b0, 1'b1, 1'b0);
		queue_cmd(500, 255);
		queue_cmd(500, 128);
		queue_cmd(500, -255);
		queue_cmd(500, -256);
		queue_cmd(500, 0);
		queue_cmd(500, 0);
		queue_cmd(50, -10);
		queue_cmd(50, 10);
		queue_cmd(950, 10);
		queue_cmd(950, -1);
		queue_cmd(0, 1);
		queue_cmd(1023, -255);
		wait_drained();

		apply_settings(16'd0, 16'hffff, 16'hffff, 1'b1, 1'b1, 1'b1);
		queue_cmd(0, 255);
		queue_cmd(1023, -255);
		queue_cmd(1023, 255);
		queue_cmd(0, -255);
		wait_drained();

		apply_settings(16'hffff, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
		write_reg(REG_SPARE_A, 16'h5a5a);
		write_reg(REG_SPARE_B, 16'ha5a5);
		queue_cmd(512, 200);
		queue_cmd(512, -200);
		wait_drained();

		apply_settings(16'd1024, 16'd0, 16'd1023, 1'b0, 1'b1, 1'b0);
		queue_cmd(700, 100);
		queue_cmd(300, -100);
		wait_drained();

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == RANDOM_PHASES - 2)
				idle_on <= 1'b0;
			case ($urandom_range(0, 7))
				0: div = 16'd1;
				1: div = 16'd1024;
				2: div = 16'd0;
				3: div = 16'($urandom);
				default: div = 16'($urandom_range(1, 1024));
			endcase
			case ($urandom_range(0, 5))
				0: begin
					mn = 16'($urandom);
					mx = 16'($urandom);
				end
				1: begin
					mx = 16'($urandom_range(0, 1023));
					mn = 16'($urandom_range(0, 1023));
				end
				default: begin
					mn = 16'($urandom_range(0, 1023));
					mx = 16'($urandom_range(mn, 1023));
				end
			endcase
			rev = 1'($urandom_range(0, 1));
			en = ($urandom_range(0, 7) != 0);
			swap = 1'($urandom_range(0, 1));
			apply_settings(div, mn, mx, rev, en, swap);
			if (rev) begin
				lo = POS_FULL - clamp_limit(mx);
				hi = POS_FULL - clamp_limit(mn);
			end else begin
				lo = clamp_limit(mn);
				hi = clamp_limit(mx);
			end
			queue_random(CMDS_PER_PHASE, lo, hi);
			wait_drained();
		end

		$display("Checked %0d results from %0d drive updates over %0d register settings.",
			results_seen, cmds_accepted, settings_used);
		$display("Register writes: %0d; break-before-make: %0d; counter restarts: %0d.",
			reg_writes, bbm_seen, restart_seen);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
